/* rtl/cce_pkg.sv */
package cce_pkg;

	localparam int EDGE_BITS = 16;

	typedef struct packed {
		logic        action;
		logic [15:0] nonce;
	} cce_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [13:0] cycle_length;
		logic [16:0] u_node;
		logic [16:0] v_node;
	} cce_res_t;

	localparam logic [2:0] STAT_LINKED   = 3'd0;
	localparam logic [2:0] STAT_ZERO     = 3'd1;
	localparam logic [2:0] STAT_CYCLE    = 3'd2;
	localparam logic [2:0] STAT_PROOF    = 3'd3;
	localparam logic [2:0] STAT_OVERFLOW = 3'd4;
	localparam logic [2:0] STAT_CLEARED  = 3'd5;

	localparam logic [1:0] REG_KEY_LOW    = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
	localparam logic [1:0] REG_PROOF_SIZE = 2'd2;

	localparam logic [7:0] PROOF_SIZE_RESET = 8'd42;

	localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
	localparam logic [63:0] SIP_FIN = 64'h00000000000000ff;

	localparam logic [3:0] SIP_HALF_LAST = 4'd11;
	localparam logic [3:0] SIP_HALF_FIN  = 4'd4;

endpackage

/* rtl/cce_ram.sv */
module cce_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/cce_sip.sv */
module cce_sip (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] msg,
	input  logic [63:0] key_low,
	input  logic [63:0] key_high,
	output logic        done,
	output logic [63:0] hash
);
	import cce_pkg::*;

	logic [63:0] a_q, b_q, c_q, d_q, m_q;
	logic [63:0] a0, c0, a_n, b_n, c_n, d_n;
	logic [3:0]  half_q;
	logic        run_q, done_q;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
		rotl = (x << s) | (x >> (64 - s));
	endfunction

	always_comb begin
		a0 = (half_q == SIP_HALF_FIN) ? (a_q ^ m_q) : a_q;
		c0 = (half_q == SIP_HALF_FIN) ? (c_q ^ SIP_FIN) : c_q;
		if (!half_q[0]) begin
			a_n = a0 + b_q;
			c_n = c0 + d_q;
			b_n = rotl(b_q, 13) ^ a_n;
			d_n = rotl(d_q, 16) ^ c_n;
			a_n = rotl(a_n, 32);
		end else begin
			c_n = c0 + b_q;
			a_n = a0 + d_q;
			b_n = rotl(b_q, 17) ^ c_n;
			d_n = rotl(d_q, 21) ^ a_n;
			c_n = rotl(c_n, 32);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			half_q <= '0;
		end else begin
			done_q <= run_q && !start && (half_q == SIP_HALF_LAST);
			if (start) begin
				run_q  <= 1'b1;
				half_q <= '0;
			end else if (run_q) begin
				half_q <= half_q + 4'd1;
				if (half_q == SIP_HALF_LAST) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= key_low ^ SIP_C0;
			b_q <= key_high ^ SIP_C1;
			c_q <= key_low ^ SIP_C2;
			d_q <= key_high ^ SIP_C3 ^ msg;
			m_q <= msg;
		end else if (run_q) begin
			a_q <= a_n;
			b_q <= b_n;
			c_q <= c_n;
			d_q <= d_n;
		end
	end

	assign done = done_q;
	assign hash = a_q ^ b_q ^ c_q ^ d_q;

endmodule

/* rtl/cuckoo_cycle_edge_insert_top.sv */
// cuckoo cycle edge insertion engine
//
// request channel (in_valid, in_stall, in_data): action 0 inserts the edge of
// nonce, action 1 clears the whole graph. one request is worked at a time;
// in_stall stays high while a request is in flight.
// result channel (out_valid, out_stall, out_data): one result per request,
// held in an output register until taken; a stalled result holds and the
// engine finishes the next request up to its result and then waits.
// apb port: key_low at 0x00, key_high at 0x08, proof_size at 0x10; write only
// while idle.
// sequence: two siphash-2-4 evaluations of 12 half rounds each on one shared
// round unit, then the u and v walks through the graph memory node by node,
// then the cycle search step by step or the path reversal node by node. the
// single graph memory port sets the walk rate.
// a clear request sweeps the graph memory one entry per cycle, over all
// 2^(EDGE_BITS+1) entries. after reset the same sweep runs before the first
// request is taken; configuration writes are taken meanwhile.
module cuckoo_cycle_edge_insert_top #(
	parameter int MAX_PATH  = 8192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cce_pkg::cce_req_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output cce_pkg::cce_res_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	import cce_pkg::*;

	localparam int NW = EDGE_BITS + 1;
	localparam int PW = $clog2(MAX_PATH);
	localparam logic [PW-1:0] PATH_LAST = PW'(MAX_PATH - 1);

	typedef enum logic [13:0] {
		S_INIT    = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_CLEAR   = 14'b00000000000100,
		S_HU_GO   = 14'b00000000001000,
		S_HU_WAIT = 14'b00000000010000,
		S_HV_GO   = 14'b00000000100000,
		S_HV_WAIT = 14'b00000001000000,
		S_WU      = 14'b00000010000000,
		S_WV      = 14'b00000100000000,
		S_ROOT    = 14'b00001000000000,
		S_CYC     = 14'b00010000000000,
		S_REV     = 14'b00100000000000,
		S_LINK    = 14'b01000000000000,
		S_FIN     = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [63:0] key_low_q, key_high_q;
	logic [7:0]  proof_q;
	logic        wr_en;

	logic [15:0]   nonce_q;
	logic [NW-1:0] u0_q, v0_q, u_root_q, v_root_q, prev_q, clr_q;
	logic [PW-1:0] nu_q, nv_q, iu_q, iv_q, k_q;
	logic          rev_u_q;
	logic [2:0]    stat_q;
	logic [13:0]   len_q;
	logic          out_valid_q;
	cce_res_t      out_q;

	logic          sip_start, sip_done;
	logic [63:0]   sip_msg, sip_hash;
	logic [NW-1:0] h_node;

	logic          g_we;
	logic [NW-1:0] g_waddr, g_wdata, g_raddr, g_rdata;
	logic          up_we, vp_we;
	logic [PW-1:0] up_waddr, vp_waddr, up_raddr, vp_raddr;
	logic [NW-1:0] up_wdata, vp_wdata, up_rdata, vp_rdata, p_rdata;

	logic [PW-1:0] m_min, iu_s, iv_s, k_init;
	logic [31:0]   len32;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			proof_q    <= PROOF_SIZE_RESET;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				REG_KEY_LOW:    key_low_q  <= pwdata;
				REG_KEY_HIGH:   key_high_q <= pwdata;
				REG_PROOF_SIZE: proof_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_KEY_LOW:    prdata = key_low_q;
			REG_KEY_HIGH:   prdata = key_high_q;
			REG_PROOF_SIZE: prdata = {56'd0, proof_q};
			default:        prdata = '0;
		endcase
	end

	assign sip_start = (state_q == S_HU_GO) || (state_q == S_HV_GO);
	assign sip_msg   = {47'd0, nonce_q, (state_q == S_HV_GO)};
	assign h_node    = {sip_hash[EDGE_BITS-1:0], (state_q == S_HV_WAIT)};

	cce_sip u_sip (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sip_start),
		.msg      (sip_msg),
		.key_low  (key_low_q),
		.key_high (key_high_q),
		.done     (sip_done),
		.hash     (sip_hash)
	);

	cce_ram #(.WIDTH(NW), .DEPTH(2 ** NW)) u_graph (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	cce_ram #(.WIDTH(NW), .DEPTH(MAX_PATH)) u_upath (
		.clk   (clk),
		.we    (up_we),
		.waddr (up_waddr),
		.wdata (up_wdata),
		.raddr (up_raddr),
		.rdata (up_rdata)
	);

	cce_ram #(.WIDTH(NW), .DEPTH(MAX_PATH)) u_vpath (
		.clk   (clk),
		.we    (vp_we),
		.waddr (vp_waddr),
		.wdata (vp_wdata),
		.raddr (vp_raddr),
		.rdata (vp_rdata)
	);

	assign p_rdata = rev_u_q ? up_rdata : vp_rdata;
	assign m_min   = (nu_q < nv_q) ? nu_q : nv_q;
	assign iu_s    = nu_q - m_min;
	assign iv_s    = nv_q - m_min;
	assign k_init  = (nu_q < nv_q) ? nu_q : nv_q;
	assign len32   = 32'(iu_q) + 32'(iv_q) + 32'd1;

	always_comb begin
		g_we     = 1'b0;
		g_waddr  = clr_q;
		g_wdata  = '0;
		g_raddr  = g_rdata;
		up_we    = 1'b0;
		up_waddr = nu_q + PW'(1);
		up_wdata = g_rdata;
		vp_we    = 1'b0;
		vp_waddr = nv_q + PW'(1);
		vp_wdata = g_rdata;
		up_raddr = k_q - PW'(1);
		vp_raddr = k_q - PW'(1);
		unique case (state_q)
			S_INIT, S_CLEAR: g_we = 1'b1;
			S_HV_WAIT: begin
				g_raddr  = u0_q;
				up_we    = sip_done;
				up_waddr = '0;
				up_wdata = u0_q;
			end
			S_WU: begin
				if (g_rdata == '0) begin
					g_raddr  = v0_q;
					vp_we    = 1'b1;
					vp_waddr = '0;
					vp_wdata = v0_q;
				end else begin
					up_we = (nu_q != PATH_LAST);
				end
			end
			S_WV: vp_we = (g_rdata != '0) && (nv_q != PATH_LAST);
			S_ROOT: begin
				up_raddr = iu_s;
				vp_raddr = iv_s;
				if (u_root_q != v_root_q) begin
					up_raddr = k_init - PW'(1);
					vp_raddr = k_init - PW'(1);
				end
			end
			S_CYC: begin
				up_raddr = iu_q + PW'(1);
				vp_raddr = iv_q + PW'(1);
			end
			S_REV: begin
				g_we    = 1'b1;
				g_waddr = prev_q;
				g_wdata = p_rdata;
			end
			S_LINK: begin
				g_we    = 1'b1;
				g_waddr = rev_u_q ? u0_q : v0_q;
				g_wdata = rev_u_q ? v0_q : u0_q;
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT, S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (&clr_q) begin
						state_q <= (state_q == S_INIT) ? S_IDLE : S_FIN;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= in_data.action ? S_CLEAR : S_HU_GO;
					end
				end
				S_HU_GO: state_q <= S_HU_WAIT;
				S_HU_WAIT: if (sip_done) state_q <= S_HV_GO;
				S_HV_GO: state_q <= S_HV_WAIT;
				S_HV_WAIT: begin
					if (sip_done) begin
						state_q <= (u0_q == '0) ? S_FIN : S_WU;
					end
				end
				S_WU: begin
					if (g_rdata == '0) begin
						state_q <= S_WV;
					end else if (nu_q == PATH_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_WV: begin
					if (g_rdata == '0) begin
						state_q <= S_ROOT;
					end else if (nv_q == PATH_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_ROOT: begin
					if (u_root_q == v_root_q) begin
						state_q <= S_CYC;
					end else begin
						state_q <= (k_init == '0) ? S_LINK : S_REV;
					end
				end
				S_CYC: if (up_rdata == vp_rdata) state_q <= S_FIN;
				S_REV: if (k_q == '0) state_q <= S_LINK;
				S_LINK: state_q <= S_FIN;
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				nonce_q <= in_data.nonce;
				stat_q  <= STAT_CLEARED;
				len_q   <= '0;
				u0_q    <= '0;
				v0_q    <= '0;
			end
			S_HU_WAIT: if (sip_done) u0_q <= h_node;
			S_HV_WAIT: begin
				if (sip_done) begin
					v0_q     <= h_node;
					u_root_q <= u0_q;
					nu_q     <= '0;
					nv_q     <= '0;
					stat_q   <= (u0_q == '0) ? STAT_ZERO : STAT_LINKED;
				end
			end
			S_WU: begin
				if (g_rdata == '0) begin
					v_root_q <= v0_q;
				end else if (nu_q == PATH_LAST) begin
					stat_q <= STAT_OVERFLOW;
				end else begin
					nu_q     <= nu_q + PW'(1);
					u_root_q <= g_rdata;
				end
			end
			S_WV: begin
				if (g_rdata != '0) begin
					if (nv_q == PATH_LAST) begin
						stat_q <= STAT_OVERFLOW;
					end else begin
						nv_q     <= nv_q + PW'(1);
						v_root_q <= g_rdata;
					end
				end
			end
			S_ROOT: begin
				iu_q    <= iu_s;
				iv_q    <= iv_s;
				rev_u_q <= (nu_q < nv_q);
				prev_q  <= (nu_q < nv_q) ? u_root_q : v_root_q;
				k_q     <= k_init - PW'(1);
			end
			S_CYC: begin
				if (up_rdata == vp_rdata) begin
					len_q  <= len32[13:0];
					stat_q <= (len32 == {24'd0, proof_q}) ? STAT_PROOF : STAT_CYCLE;
				end else begin
					iu_q <= iu_q + PW'(1);
					iv_q <= iv_q + PW'(1);
				end
			end
			S_REV: begin
				prev_q <= p_rdata;
				k_q    <= k_q - PW'(1);
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_q.status       <= stat_q;
					out_q.cycle_length <= len_q;
					out_q.u_node       <= (stat_q == STAT_ZERO) ? 17'd0 : u0_q[16:0];
					out_q.v_node       <= v0_q[16:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != S_IDLE)
		else $error("request accepted but engine stayed idle");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !g_we && !up_we && !vp_we)
		else $error("memory written while idle");

	a_sip_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sip_done |-> state_q == S_HU_WAIT || state_q == S_HV_WAIT)
		else $error("hash finished outside a wait state");

	a_fin_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && !(out_valid_q && out_stall) |=> out_valid_q)
		else $error("result not presented after finish");

endmodule
